// File: design/utcl_pkg.sv
// UTC to local date/time converter: shared types, constants and helper functions.
// Used by every module of the converter but utcl_chk; depends on nothing else.
package utcl_pkg;

	// Configuration register indexes
	localparam logic CFG_TZ_EAST   = 1'b0;
	localparam logic CFG_TZ_OFFSET = 1'b1;

	localparam logic [16:0] SecsPerDay  = 17'd86400;
	localparam logic [16:0] SecsPerHour = 17'd3600;
	localparam logic [16:0] SecsPerMin  = 17'd60;

	// Reciprocals for exact division by constants (multiply, then shift)
	localparam logic [17:0] HourRecip = 18'd149131; // 2^29 / 3600, rounded up
	localparam int          HourShift = 29;
	localparam logic [17:0] MinRecip  = 18'd139811; // 2^23 / 60, rounded up
	localparam int          MinShift  = 23;
	localparam logic [12:0] RemRecip  = 13'd4370;   // 2^18 / 60, rounded up
	localparam int          RemShift  = 18;

	// Stage advance strobes from the pipeline control
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_en_t;

	// Gregorian leap year of 2000+yr; only 2000 and 2100 fall on a century
	function automatic logic is_leap(input logic [6:0] yr);
		return (yr[1:0] == 2'd0) && (yr != 7'd100);
	endfunction

	// Days in a month; months outside 1..12 have 31
	function automatic logic [4:0] month_days(input logic [3:0] mo, input logic [6:0] yr);
		logic [4:0] d;
		case (mo)
			4'd2: begin
				d = is_leap(yr) ? 5'd29 : 5'd28;
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				d = 5'd30;
			end
			default: begin
				d = 5'd31;
			end
		endcase
		return d;
	endfunction

	// Packed BCD of a value below 100; quotient by ten through a reciprocal
	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [14:0] p;
		logic [3:0]  q;
		logic [6:0]  r;
		p = 15'(v) * 15'd205;
		q = p[14:11];
		r = v - 7'(q) * 7'd10;
		return {q, r[3:0]};
	endfunction

	// Month term of the weekday sum: ((m + 1) * 13) / 5
	function automatic logic [5:0] month_term(input logic [3:0] m);
		logic [5:0] t;
		case (m)
			4'd0:    t = 6'd2;
			4'd1:    t = 6'd5;
			4'd2:    t = 6'd7;
			4'd3:    t = 6'd10;
			4'd4:    t = 6'd13;
			4'd5:    t = 6'd15;
			4'd6:    t = 6'd18;
			4'd7:    t = 6'd20;
			4'd8:    t = 6'd23;
			4'd9:    t = 6'd26;
			4'd10:   t = 6'd28;
			4'd11:   t = 6'd31;
			4'd12:   t = 6'd33;
			4'd13:   t = 6'd36;
			4'd14:   t = 6'd39;
			default: t = 6'd41;
		endcase
		return t;
	endfunction

	// Modulo 7 of a 9-bit value: octal digits sum, since 8 is 1 mod 7
	function automatic logic [2:0] mod7(input logic [8:0] v);
		logic [4:0] a;
		logic [3:0] b;
		a = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[8:6]);
		b = 4'(a[2:0]) + 4'(a[4:3]);
		return (b >= 4'd7) ? 3'(b - 4'd7) : b[2:0];
	endfunction

endpackage

// File: design/utc_to_local_date_time_unit.sv
// UTC to local date/time converter, top level: ports, time-zone registers and pipe.
// Depends on utcl_pkg, utcl_ctl, utcl_shift and utcl_split.
//
//   Channel  Direction  Width  Carries
//   s_axis   in         40     UTC year, month, day, hour, minute, second (binary)
//   m_axis   out        64     local date/time in BCD, weekday, local second of day
//   cfg      in         1+16   tz_east (index 0), tz_offset_seconds (index 1)
//
// Six register stages; one item per cycle sustained while m_axis does not stall.
// The deepest stage work is one constant-reciprocal multiply of the second of day.
// A stall at m_axis holds the full stages behind it; empty stages still fill.
// Reset clears the valid bits and both time-zone registers.
module utc_to_local_date_time_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// utc_year[6:0], utc_month[10:7], utc_day[15:11], utc_hour[20:16],
	// utc_minute[26:21], utc_second[32:27], zero fill [39:33]
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// local_year_bcd[7:0], local_month_bcd[12:8], local_day_bcd[18:13],
	// local_hour_bcd[24:19], local_minute_bcd[31:25], local_second_bcd[38:32],
	// weekday[41:39], local_second_of_day[58:42], zero fill [63:59]
	output logic [63:0] m_axis_tdata,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata
);
	import utcl_pkg::*;

	logic        tz_east_q;
	logic [15:0] tz_offset_q;
	stage_en_t   en;

	logic [6:0]  year_s2;
	logic [3:0]  month_s2;
	logic [4:0]  day_s2;
	logic [16:0] local_s2;

	logic [7:0]  year_bcd_s6;
	logic [4:0]  month_bcd_s6;
	logic [5:0]  day_bcd_s6;
	logic [5:0]  hour_bcd_s6;
	logic [6:0]  minute_bcd_s6;
	logic [6:0]  second_bcd_s6;
	logic [2:0]  weekday_s6;
	logic [16:0] sod_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tz_east_q   <= 1'b0;
			tz_offset_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_TZ_EAST: begin
					tz_east_q <= cfg_wdata[0];
				end
				CFG_TZ_OFFSET: begin
					tz_offset_q <= cfg_wdata;
				end
				default: begin
					tz_east_q <= tz_east_q;
				end
			endcase
		end
	end

	utcl_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.en        (en)
	);

	utcl_shift u_shift (
		.clk        (clk),
		.en         (en),
		.tz_east    (tz_east_q),
		.tz_offset  (tz_offset_q),
		.utc_year   (s_axis_tdata[6:0]),
		.utc_month  (s_axis_tdata[10:7]),
		.utc_day    (s_axis_tdata[15:11]),
		.utc_hour   (s_axis_tdata[20:16]),
		.utc_minute (s_axis_tdata[26:21]),
		.utc_second (s_axis_tdata[32:27]),
		.year_s2    (year_s2),
		.month_s2   (month_s2),
		.day_s2     (day_s2),
		.local_s2   (local_s2)
	);

	utcl_split u_split (
		.clk           (clk),
		.en            (en),
		.year_s2       (year_s2),
		.month_s2      (month_s2),
		.day_s2        (day_s2),
		.local_s2      (local_s2),
		.year_bcd_s6   (year_bcd_s6),
		.month_bcd_s6  (month_bcd_s6),
		.day_bcd_s6    (day_bcd_s6),
		.hour_bcd_s6   (hour_bcd_s6),
		.minute_bcd_s6 (minute_bcd_s6),
		.second_bcd_s6 (second_bcd_s6),
		.weekday_s6    (weekday_s6),
		.sod_s6        (sod_s6)
	);

	assign m_axis_tdata = {5'd0, sod_s6, weekday_s6, second_bcd_s6, minute_bcd_s6,
		hour_bcd_s6, day_bcd_s6, month_bcd_s6, year_bcd_s6};

endmodule

// File: design/utcl_ctl.sv
// UTC to local converter: valid bits and stage advance strobes of the six-stage pipe.
// Depends on utcl_pkg.
module utcl_ctl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output utcl_pkg::stage_en_t en
);
	import utcl_pkg::*;

	logic [5:0] valid_q;

	// A stage loads when it is empty or its contents move on
	always_comb begin
		en.s6 = !valid_q[5] || out_ready;
		en.s5 = !valid_q[4] || en.s6;
		en.s4 = !valid_q[3] || en.s5;
		en.s3 = !valid_q[2] || en.s4;
		en.s2 = !valid_q[1] || en.s3;
		en.s1 = !valid_q[0] || en.s2;
	end

	assign in_ready  = en.s1;
	assign out_valid = valid_q[5];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en.s1) valid_q[0] <= in_valid;
			if (en.s2) valid_q[1] <= valid_q[0];
			if (en.s3) valid_q[2] <= valid_q[1];
			if (en.s4) valid_q[3] <= valid_q[2];
			if (en.s5) valid_q[4] <= valid_q[3];
			if (en.s6) valid_q[5] <= valid_q[4];
		end
	end

endmodule

// File: design/utcl_shift.sv
// UTC to local converter, stages 1 and 2: second of day, offset and one-day date step.
// Depends on utcl_pkg.
module utcl_shift (
	input  logic               clk,
	input  utcl_pkg::stage_en_t en,
	input  logic               tz_east,
	input  logic [15:0]        tz_offset,
	input  logic [6:0]         utc_year,
	input  logic [3:0]         utc_month,
	input  logic [4:0]         utc_day,
	input  logic [4:0]         utc_hour,
	input  logic [5:0]         utc_minute,
	input  logic [5:0]         utc_second,
	output logic [6:0]         year_s2,
	output logic [3:0]         month_s2,
	output logic [4:0]         day_s2,
	output logic [16:0]        local_s2
);
	import utcl_pkg::*;

	logic [6:0]  year_s1;
	logic [3:0]  month_s1;
	logic [4:0]  day_s1;
	logic [4:0]  mlen_s1;
	logic [16:0] secs_s1;

	logic [16:0] secs_c;
	logic [17:0] sum_c;
	logic [17:0] diff_c;
	logic [16:0] local_c;
	logic        fwd_c;
	logic        back_c;
	logic [6:0]  year_c;
	logic [3:0]  month_c;
	logic [4:0]  day_c;

	assign secs_c = 17'(utc_hour) * SecsPerHour + 17'(utc_minute) * SecsPerMin
		+ 17'(utc_second);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			year_s1  <= utc_year;
			month_s1 <= utc_month;
			day_s1   <= utc_day;
			mlen_s1  <= month_days(utc_month, utc_year);
			secs_s1  <= secs_c;
		end
	end

	// Apply the offset and find whether the day rolls
	always_comb begin
		sum_c  = 18'(secs_s1) + 18'(tz_offset);
		diff_c = 18'(secs_s1) - 18'(tz_offset);
		fwd_c  = 1'b0;
		back_c = 1'b0;
		if (tz_east) begin
			if (sum_c < 18'(SecsPerDay)) begin
				local_c = sum_c[16:0];
			end else begin
				local_c = 17'(sum_c - 18'(SecsPerDay));
				fwd_c   = 1'b1;
			end
		end else begin
			if (secs_s1 >= 17'(tz_offset)) begin
				local_c = diff_c[16:0];
			end else begin
				local_c = 17'(diff_c + 18'(SecsPerDay));
				back_c  = 1'b1;
			end
		end
	end

	// Step the date one day forward or back
	always_comb begin
		year_c  = year_s1;
		month_c = month_s1;
		day_c   = day_s1;
		if (fwd_c) begin
			if (day_s1 < mlen_s1) begin
				day_c = day_s1 + 5'd1;
			end else begin
				day_c = 5'd1;
				if (month_s1 < 4'd12) begin
					month_c = month_s1 + 4'd1;
				end else begin
					month_c = 4'd1;
					year_c  = (year_s1 == 7'd99) ? 7'd0 : year_s1 + 7'd1;
				end
			end
		end else if (back_c) begin
			if (day_s1 > 5'd1) begin
				day_c = day_s1 - 5'd1;
			end else if (month_s1 > 4'd1) begin
				month_c = month_s1 - 4'd1;
				day_c   = month_days(month_s1 - 4'd1, year_s1);
			end else begin
				year_c  = (year_s1 == 7'd0) ? 7'd99 : year_s1 - 7'd1;
				month_c = 4'd12;
				day_c   = 5'd31;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			year_s2  <= year_c;
			month_s2 <= month_c;
			day_s2   <= day_c;
			local_s2 <= local_c;
		end
	end

endmodule

// File: design/utcl_split.sv
// UTC to local converter, stages 3 to 6: hour/minute/second split, BCD and weekday.
// Depends on utcl_pkg.
module utcl_split (
	input  logic               clk,
	input  utcl_pkg::stage_en_t en,
	input  logic [6:0]         year_s2,
	input  logic [3:0]         month_s2,
	input  logic [4:0]         day_s2,
	input  logic [16:0]        local_s2,
	output logic [7:0]         year_bcd_s6,
	output logic [4:0]         month_bcd_s6,
	output logic [5:0]         day_bcd_s6,
	output logic [5:0]         hour_bcd_s6,
	output logic [6:0]         minute_bcd_s6,
	output logic [6:0]         second_bcd_s6,
	output logic [2:0]         weekday_s6,
	output logic [16:0]        sod_s6
);
	import utcl_pkg::*;

	// Stage 3
	logic [34:0] hprod_c;
	logic [34:0] mprod_c;
	logic        early_c;
	logic [3:0]  zmonth_c;
	logic [7:0]  zyear_c;
	logic [8:0]  wsum_c;
	logic [7:0]  year_bcd_s3;
	logic [7:0]  month_bcd_s3;
	logic [7:0]  day_bcd_s3;
	logic [8:0]  wsum_s3;
	logic [5:0]  hour_s3;
	logic [11:0] tmin_s3;
	logic [16:0] local_s3;

	// Stage 4
	logic [16:0] rem_c;
	logic [16:0] sec_c;
	logic [7:0]  year_bcd_s4;
	logic [4:0]  month_bcd_s4;
	logic [5:0]  day_bcd_s4;
	logic [5:0]  hour_bcd_s4;
	logic [2:0]  weekday_s4;
	logic [11:0] rem_s4;
	logic [5:0]  sec_s4;
	logic [16:0] local_s4;

	// Stage 5
	logic [24:0] rprod_c;
	logic [7:0]  sec_bcd_c;
	logic [7:0]  year_bcd_s5;
	logic [4:0]  month_bcd_s5;
	logic [5:0]  day_bcd_s5;
	logic [5:0]  hour_bcd_s5;
	logic [2:0]  weekday_s5;
	logic [5:0]  minute_s5;
	logic [6:0]  second_bcd_s5;
	logic [16:0] local_s5;

	logic [7:0]  min_bcd_c;

	// Stage 3: hour and total minutes by reciprocal, date BCD, weekday sum.
	// January and February count as months 13 and 14 of the year before;
	// the year is biased by 28 so it stays positive.
	always_comb begin
		hprod_c  = 35'(local_s2) * 35'(HourRecip);
		mprod_c  = 35'(local_s2) * 35'(MinRecip);
		early_c  = (month_s2 < 4'd3);
		zmonth_c = early_c ? month_s2 + 4'd12 : month_s2;
		zyear_c  = 8'(year_s2) + 8'd28 - 8'(early_c);
		wsum_c   = 9'(zyear_c) + 9'(zyear_c[7:2]) + 9'(month_term(zmonth_c))
			+ 9'(day_s2) + 9'd6;
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			year_bcd_s3  <= to_bcd(year_s2);
			month_bcd_s3 <= to_bcd(7'(month_s2));
			day_bcd_s3   <= to_bcd(7'(day_s2));
			wsum_s3      <= wsum_c;
			hour_s3      <= hprod_c[HourShift+5:HourShift];
			tmin_s3      <= mprod_c[MinShift+11:MinShift];
			local_s3     <= local_s2;
		end
	end

	// Stage 4: remainders within the hour and within the minute
	always_comb begin
		rem_c = local_s3 - 17'(hour_s3) * SecsPerHour;
		sec_c = local_s3 - 17'(tmin_s3) * SecsPerMin;
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			year_bcd_s4  <= year_bcd_s3;
			month_bcd_s4 <= month_bcd_s3[4:0];
			day_bcd_s4   <= day_bcd_s3[5:0];
			hour_bcd_s4  <= 6'(to_bcd(7'(hour_s3)));
			weekday_s4   <= mod7(wsum_s3);
			rem_s4       <= rem_c[11:0];
			sec_s4       <= sec_c[5:0];
			local_s4     <= local_s3;
		end
	end

	// Stage 5: minute within the hour, second to BCD
	always_comb begin
		rprod_c   = 25'(rem_s4) * 25'(RemRecip);
		sec_bcd_c = to_bcd(7'(sec_s4));
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			year_bcd_s5   <= year_bcd_s4;
			month_bcd_s5  <= month_bcd_s4;
			day_bcd_s5    <= day_bcd_s4;
			hour_bcd_s5   <= hour_bcd_s4;
			weekday_s5    <= weekday_s4;
			minute_s5     <= rprod_c[RemShift+5:RemShift];
			second_bcd_s5 <= sec_bcd_c[6:0];
			local_s5      <= local_s4;
		end
	end

	// Stage 6: minute to BCD, output register
	assign min_bcd_c = to_bcd(7'(minute_s5));

	always_ff @(posedge clk) begin
		if (en.s6) begin
			year_bcd_s6   <= year_bcd_s5;
			month_bcd_s6  <= month_bcd_s5;
			day_bcd_s6    <= day_bcd_s5;
			hour_bcd_s6   <= hour_bcd_s5;
			minute_bcd_s6 <= min_bcd_c[6:0];
			second_bcd_s6 <= second_bcd_s5;
			weekday_s6    <= weekday_s5;
			sod_s6        <= local_s5;
		end
	end

endmodule

// File: design/utcl_chk.sv
// UTC to local converter: port-level checks over time, bound to the top level.
// Depends only on the top level's ports.
module utcl_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata
);

	// Hold a waiting result until it is taken
	a_out_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result item dropped while stalled");

	a_out_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result item changed while stalled");

	// Input side backs off only when the pipe is full behind a stalled result
	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without a downstream stall");

	// Minute and second digits and weekday stay in range
	a_out_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[28:25] <= 4'd9) && (m_axis_tdata[31:29] <= 3'd5)
			&& (m_axis_tdata[35:32] <= 4'd9) && (m_axis_tdata[38:36] <= 3'd5)
			&& (m_axis_tdata[41:39] <= 3'd6))
		else $error("result item field out of range");

endmodule

bind utc_to_local_date_time_unit utcl_chk u_utcl_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// File: bench/utcl_checker.sv
`timescale 1ns / 1ps
// Checker for the UTC to local date/time converter: watches both streams and the
// register port, predicts each local time stamp and compares it field by field.
// Depends on utcl_pkg for the register indexes.
module utcl_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	output int          fail_count,
	output int          outstanding
);
	import utcl_pkg::*;

	localparam int unsigned DAY_SECS = 86400;

	typedef struct packed {
		logic [6:0] fill;
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [4:0] day;
		logic [3:0] month;
		logic [6:0] year;
	} utc_stamp_t;

	typedef struct packed {
		logic [4:0]  fill;
		logic [16:0] sec_of_day;
		logic [2:0]  weekday;
		logic [6:0]  second;
		logic [6:0]  minute;
		logic [5:0]  hour;
		logic [5:0]  day;
		logic [4:0]  month;
		logic [7:0]  year;
	} local_stamp_t;

	logic         zone_east;
	logic [15:0]  zone_offset;
	local_stamp_t pending_stamps[$];
	local_stamp_t got_stamp;
	local_stamp_t want_stamp;

	function automatic int unsigned days_in_month(input int unsigned mo, input int unsigned yr);
		int unsigned full;
		full = 2000 + yr;
		case (mo)
			2: begin
				days_in_month = ((full % 4 == 0) && ((full % 100 != 0) || (full % 400 == 0)))
					? 29 : 28;
			end
			4, 6, 9, 11: begin
				days_in_month = 30;
			end
			default: begin
				days_in_month = 31;
			end
		endcase
	endfunction

	function automatic int unsigned bcd(input int unsigned v);
		return ((v / 10) << 4) | (v % 10);
	endfunction

	function automatic local_stamp_t predict_local(input utc_stamp_t u);
		local_stamp_t r;
		int unsigned  yr, mo, dy, secs, mlen, lsec, zm, zy;
		yr = u.year;
		mo = u.month;
		dy = u.day;
		secs = u.hour * 3600 + u.minute * 60 + u.second;
		mlen = days_in_month(mo, yr);
		if (zone_east) begin
			if (secs + zone_offset < DAY_SECS) begin
				lsec = secs + zone_offset;
			end else begin
				// step one day forward
				lsec = secs + zone_offset - DAY_SECS;
				if (dy < mlen) begin
					dy++;
				end else begin
					dy = 1;
					if (mo < 12) begin
						mo++;
					end else begin
						mo = 1;
						yr = (yr == 99) ? 0 : ((yr + 1) & 'h7F);
					end
				end
			end
		end else begin
			if (secs >= zone_offset) begin
				lsec = secs - zone_offset;
			end else begin
				// step one day back
				lsec = secs + DAY_SECS - zone_offset;
				if (dy > 1) begin
					dy--;
				end else if (mo > 1) begin
					mo--;
					dy = days_in_month(mo, yr);
				end else begin
					yr = (yr == 0) ? 99 : yr - 1;
					mo = 12;
					dy = 31;
				end
			end
		end
		// January and February count as months 13 and 14 of the year before;
		// the year is offset by 28 to stay positive across year 00
		zm = mo;
		zy = yr + 28;
		if (zm < 3) begin
			zm += 12;
			zy -= 1;
		end
		r = '0;
		r.year       = bcd(yr);
		r.month      = bcd(mo);
		r.day        = bcd(dy);
		r.hour       = bcd(lsec / 3600);
		r.minute     = bcd((lsec % 3600) / 60);
		r.second     = bcd(lsec % 60);
		r.weekday    = (zy + zy / 4 + ((zm + 1) * 13) / 5 + dy + 6) % 7;
		r.sec_of_day = lsec;
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_stamps.delete();
			zone_east = 1'b0;
			zone_offset = 16'd0;
			fail_count = 0;
			outstanding <= 0;
		end else begin
			// retire before accepting so an early result cannot match its own item
			if (m_axis_tvalid && m_axis_tready) begin
				got_stamp = m_axis_tdata;
				if (pending_stamps.size() == 0) begin
					$error("local time item with no UTC item outstanding: %h", m_axis_tdata);
					fail_count++;
				end else begin
					want_stamp = pending_stamps.pop_front();
					check_field("local_year_bcd", want_stamp.year, got_stamp.year);
					check_field("local_month_bcd", want_stamp.month, got_stamp.month);
					check_field("local_day_bcd", want_stamp.day, got_stamp.day);
					check_field("local_hour_bcd", want_stamp.hour, got_stamp.hour);
					check_field("local_minute_bcd", want_stamp.minute, got_stamp.minute);
					check_field("local_second_bcd", want_stamp.second, got_stamp.second);
					check_field("weekday", want_stamp.weekday, got_stamp.weekday);
					check_field("local_second_of_day", want_stamp.sec_of_day,
						got_stamp.sec_of_day);
					check_field("zero fill", want_stamp.fill, got_stamp.fill);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				pending_stamps.push_back(predict_local(s_axis_tdata));
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_TZ_EAST: begin
						zone_east = cfg_wdata[0];
					end
					CFG_TZ_OFFSET: begin
						zone_offset = cfg_wdata;
					end
					default: begin
						zone_east = zone_east;
					end
				endcase
			end
			outstanding <= pending_stamps.size();
		end
	end

endmodule

// File: bench/tb_utc_to_local_date_time_unit.sv
`timescale 1ns / 1ps
// Testbench top for the UTC to local date/time converter: clock, reset, time-zone
// settings, UTC time stamps and sink stalls. Depends on utcl_pkg, the block and utcl_checker.
module tb_utc_to_local_date_time_unit;
	import utcl_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_ITEMS  = 48;
	localparam int RANDOM_PHASES = 11;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic        cfg_wr_en;
	logic        cfg_index;
	logic [15:0] cfg_wdata;
	int          fail_count;
	int          outstanding;
	int          cycle_count;
	logic        sender_calm;

	utc_to_local_date_time_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	utcl_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_utc_to_local_date_time_unit: FAIL");
			$finish;
		end
	end

	// Sink: ready runs of random length, mostly short stalls, now and then a long one
	initial begin : sink_stalls
		int roll;
		int hold;
		forever begin
			roll = $urandom_range(0, 99);
			hold = (roll < 80) ? $urandom_range(1, 8) :
				(roll < 95) ? $urandom_range(20, 60) : $urandom_range(150, 400);
			m_axis_tready <= 1'b1;
			repeat (hold) @(posedge clk);
			roll = $urandom_range(0, 99);
			hold = (roll < 50) ? 1 : (roll < 90) ? $urandom_range(2, 4) : $urandom_range(15, 50);
			m_axis_tready <= 1'b0;
			repeat (hold) @(posedge clk);
		end
	end

	task automatic send_stamp(input logic [6:0] yy, input logic [3:0] mo, input logic [4:0] dd,
		input logic [4:0] hh, input logic [5:0] mi, input logic [5:0] ss);
		int roll;
		int gap;
		gap = 0;
		if (!sender_calm) begin
			roll = $urandom_range(0, 99);
			gap = (roll < 55) ? 0 : (roll < 93) ? $urandom_range(1, 3) : $urandom_range(8, 40);
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, ss, mi, hh, dd, mo, yy};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Hold the source off until every local time item has come back
	task automatic await_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic set_zone(input logic east, input logic [15:0] offset);
		await_results();
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_TZ_EAST;
		cfg_wdata <= {15'd0, east};
		@(posedge clk);
		cfg_index <= CFG_TZ_OFFSET;
		cfg_wdata <= offset;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin : stimulus
		int          roll;
		logic        east;
		logic [15:0] offset;
		logic [6:0]  yy;
		logic [4:0]  dd;
		logic [4:0]  hh;
		arst_n = 1'b0;
		sender_calm = 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_TZ_EAST;
		cfg_wdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: no shift at all; January and February of year 00
		send_stamp(7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
		send_stamp(7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
		send_stamp(7'd0, 4'd2, 5'd14, 5'd12, 6'd0, 6'd0);

		// largest eastward shift: year wrap, leap February, bad day, month ends
		set_zone(1'b1, 16'hFFFF);
		send_stamp(7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
		send_stamp(7'd0, 4'd2, 5'd28, 5'd20, 6'd0, 6'd0);
		send_stamp(7'd0, 4'd2, 5'd29, 5'd20, 6'd0, 6'd0);
		send_stamp(7'd1, 4'd2, 5'd28, 5'd20, 6'd0, 6'd0);
		send_stamp(7'd1, 4'd2, 5'd31, 5'd20, 6'd0, 6'd0);
		send_stamp(7'd0, 4'd4, 5'd30, 5'd23, 6'd0, 6'd0);
		send_stamp(7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);

		// largest westward shift: year wrap back, into February and January of 00
		set_zone(1'b0, 16'hFFFF);
		send_stamp(7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
		send_stamp(7'd0, 4'd3, 5'd1, 5'd5, 6'd0, 6'd0);
		send_stamp(7'd1, 4'd3, 5'd1, 5'd5, 6'd0, 6'd0);
		send_stamp(7'd0, 4'd5, 5'd1, 5'd0, 6'd30, 6'd0);
		send_stamp(7'd0, 4'd2, 5'd1, 5'd1, 6'd0, 6'd0);
		send_stamp(7'd50, 4'd1, 5'd1, 5'd10, 6'd0, 6'd0);
		send_stamp(7'd0, 4'd1, 5'd15, 5'd23, 6'd0, 6'd0);

		// one second east: rollover exactly at midnight and just short of it
		set_zone(1'b1, 16'd1);
		send_stamp(7'd7, 4'd6, 5'd30, 5'd23, 6'd59, 6'd59);
		send_stamp(7'd7, 4'd6, 5'd30, 5'd23, 6'd59, 6'd58);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			east = phase[0];
			roll = $urandom_range(0, 3);
			offset = (phase == 0) ? 16'd0 :
				(roll == 0) ? 16'hFFFF :
				(roll == 1) ? 16'($urandom_range(0, 255)) :
				(roll == 2) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(60000, 65535));
			set_zone(east, offset);
			sender_calm = (phase % 4 == 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// lean towards century ends, month ends and times near midnight
				yy = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 7'd0 : 7'd99) :
					7'($urandom_range(0, 99));
				dd = $urandom_range(0, 1) ? 5'($urandom_range(27, 31)) :
					($urandom_range(0, 3) == 0) ? 5'd1 : 5'($urandom_range(1, 31));
				hh = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 5'd23 : 5'd0) :
					5'($urandom_range(0, 23));
				send_stamp(yy, 4'($urandom_range(1, 12)), dd, hh,
					6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)));
			end
		end

		await_results();
		repeat (12) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_utc_to_local_date_time_unit: PASS");
		end else begin
			$display("tb_utc_to_local_date_time_unit: FAIL");
		end
		$finish;
	end

endmodule
